// File: rtl/core/piecewise_linear_table_interpolator_assert.svh
// Assertion macros for the piecewise linear interpolator.
// Used by the top level; expects clk and arst_n in scope.
`ifndef PIECEWISE_LINEAR_TABLE_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_TABLE_INTERPOLATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLTI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLTI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/plti_pkg.sv
// Shared types and codes for the piecewise linear interpolator.
// No dependencies.
`timescale 1ns / 1ps

package plti_pkg;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	localparam int DATA_W = 32;
	localparam int DIV_STEPS = 32;

	typedef enum logic [2:0] {
		PLTI_IDLE,
		PLTI_WALK,
		PLTI_MUL,
		PLTI_DIV,
		PLTI_FIN,
		PLTI_RESP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic walk;
		logic seg_load;
		logic mul;
		logic div;
		logic fin;
		logic miss;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_query;
		logic hit;
		logic miss;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/core/plti_ctrl.sv
// Sequencer for the interpolator: accept, segment walk, multiply, divide, respond.
// Depends on plti_pkg.
`timescale 1ns / 1ps

module plti_ctrl
	import plti_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  sts_t   sts,
	output cmd_t   cmd,
	output state_t state
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PLTI_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PLTI_IDLE: begin
				if (in_valid) begin
					state_d = sts.is_query ? PLTI_WALK : PLTI_RESP;
				end
			end
			PLTI_WALK: begin
				priority if (sts.hit) begin
					state_d = PLTI_MUL;
				end else if (sts.miss) begin
					state_d = PLTI_RESP;
				end
			end
			PLTI_MUL:  state_d = PLTI_DIV;
			PLTI_DIV: begin
				if (sts.div_last) begin
					state_d = PLTI_FIN;
				end
			end
			PLTI_FIN:  state_d = PLTI_RESP;
			PLTI_RESP: begin
				if (sts.out_free) begin
					state_d = PLTI_IDLE;
				end
			end
			default:   state_d = PLTI_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			PLTI_IDLE: cmd.accept = in_valid;
			PLTI_WALK: begin
				cmd.seg_load = sts.hit;
				cmd.miss     = !sts.hit && sts.miss;
				cmd.walk     = !sts.hit && !sts.miss;
			end
			PLTI_MUL:  cmd.mul  = 1'b1;
			PLTI_DIV:  cmd.div  = 1'b1;
			PLTI_FIN:  cmd.fin  = 1'b1;
			PLTI_RESP: cmd.emit = sts.out_free;
			default:   cmd = '0;
		endcase
	end

	assign in_ready = (state_q == PLTI_IDLE);
	assign state    = state_q;

endmodule

// File: rtl/core/plti_dpath.sv
// Datapath: breakpoint memories, segment walk, 32x32 multiplier,
// restoring divider and output register. Depends on plti_pkg.
`timescale 1ns / 1ps

module plti_dpath
	import plti_pkg::*;
#(
	parameter int MAX_POINTS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic [1:0]               action,
	input  logic signed [DATA_W-1:0] key_x,
	input  logic signed [DATA_W-1:0] point_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] result_value,
	output logic [1:0]               status
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int DC_W  = $clog2(DIV_STEPS);

	logic [DATA_W-1:0] mem_x [MAX_POINTS];
	logic [DATA_W-1:0] mem_y [MAX_POINTS];

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] ptr_q;
	logic             cur_vld_q, seg_vld_q;
	logic signed [DATA_W-1:0] key_q;
	logic signed [DATA_W-1:0] cur_x_q, cur_y_q, prv_x_q, prv_y_q;

	logic [DATA_W-1:0] dx_q, t_q, mag_q, rem_q, low_q;
	logic signed [DATA_W-1:0] y0_q;
	logic              neg_q, dx_zero_q;
	logic [DC_W-1:0]   div_cnt_q;

	logic signed [DATA_W-1:0] pend_val_q;
	logic [1:0]               pend_st_q;
	logic                     out_vld_q;
	logic signed [DATA_W-1:0] res_q;
	logic [1:0]               st_q;

	logic                 full, exhausted, rd_ok;
	logic                 do_append;
	logic [DATA_W-1:0]    dx, t, mag;
	logic signed [DATA_W:0] dy;
	logic [DATA_W:0]      trial, trial_sub;
	logic                 ge;
	logic signed [DATA_W-1:0] final_val;

	assign full      = (cnt_q >= CNT_W'(MAX_POINTS));
	assign rd_ok     = (ptr_q < cnt_q);
	assign exhausted = !rd_ok && !cur_vld_q;
	assign do_append = cmd.accept && (action == ACT_APPEND) && !full;

	// Segment set-up: x0 <= key <= x1 holds, so the unsigned differences are exact.
	assign dx  = cur_x_q - prv_x_q;
	assign t   = key_q - prv_x_q;
	assign dy  = {cur_y_q[DATA_W-1], cur_y_q} - {prv_y_q[DATA_W-1], prv_y_q};
	assign mag = dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];

	// Quotient is below 2^32, so the high product half is already below dx.
	assign trial     = {rem_q, low_q[DATA_W-1]};
	assign ge        = (trial >= {1'b0, dx_q});
	assign trial_sub = trial - {1'b0, dx_q};

	assign final_val = dx_zero_q ? y0_q :
		(neg_q ? y0_q - $signed(low_q) : y0_q + $signed(low_q));

	assign sts.is_query = (action == ACT_QUERY);
	assign sts.hit      = seg_vld_q && (prv_x_q <= key_q) && (key_q <= cur_x_q);
	assign sts.miss     = exhausted;
	assign sts.div_last = (div_cnt_q == DC_W'(DIV_STEPS - 1));
	assign sts.out_free = !out_vld_q || out_ready;

	// breakpoint store, no reset
	always_ff @(posedge clk) begin
		if (do_append) begin
			mem_x[cnt_q[IDX_W-1:0]] <= key_x;
			mem_y[cnt_q[IDX_W-1:0]] <= point_value;
		end
		if (cmd.walk && rd_ok) begin
			cur_x_q <= mem_x[ptr_q[IDX_W-1:0]];
			cur_y_q <= mem_y[ptr_q[IDX_W-1:0]];
			prv_x_q <= cur_x_q;
			prv_y_q <= cur_y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			ptr_q     <= '0;
			cur_vld_q <= 1'b0;
			seg_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (cmd.accept) begin
				if (action == ACT_CLEAR) begin
					cnt_q <= '0;
				end else if (do_append) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				ptr_q     <= '0;
				cur_vld_q <= 1'b0;
				seg_vld_q <= 1'b0;
			end else if (cmd.walk) begin
				if (rd_ok) begin
					ptr_q <= ptr_q + CNT_W'(1);
				end
				seg_vld_q <= rd_ok && cur_vld_q;
				cur_vld_q <= rd_ok;
			end
			if (cmd.mul) begin
				div_cnt_q <= '0;
			end else if (cmd.div) begin
				div_cnt_q <= div_cnt_q + DC_W'(1);
			end
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// arithmetic and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q      <= key_x;
			pend_val_q <= '0;
			pend_st_q  <= (action == ACT_APPEND && full) ? ST_FULL : ST_OK;
		end
		if (cmd.miss) begin
			pend_val_q <= '0;
			pend_st_q  <= ST_NOT_FOUND;
		end
		if (cmd.seg_load) begin
			dx_q      <= dx;
			t_q       <= t;
			mag_q     <= mag;
			neg_q     <= dy[DATA_W];
			y0_q      <= prv_y_q;
			dx_zero_q <= (dx == '0);
		end
		if (cmd.mul) begin
			{rem_q, low_q} <= mag_q * t_q;
		end
		if (cmd.div) begin
			rem_q <= ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
			low_q <= {low_q[DATA_W-2:0], ge};
		end
		if (cmd.fin) begin
			pend_val_q <= final_val;
			pend_st_q  <= ST_OK;
		end
		if (cmd.emit) begin
			res_q <= pend_val_q;
			st_q  <= pend_st_q;
		end
	end

	assign out_valid    = out_vld_q;
	assign result_value = res_q;
	assign status       = st_q;

endmodule

// File: rtl/core/piecewise_linear_table_interpolator.sv
// Piecewise linear interpolator over a table of up to MAX_POINTS breakpoints.
// Input channel: in_valid/in_ready with action, key_x, point_value.
//   action clear empties the table, append stores (key_x, point_value) at
//   the end, query interpolates at key_x. Values are signed Q16.16.
// Output channel: out_valid/out_ready with result_value and status; exactly
//   one result per input transfer, in order.
// One item is in flight at a time; in_ready is high only when idle.
// Clear and append: the item goes straight to the response state, and its
//   result is loaded into the output register from there.
// Query on n stored points: walk at one memory read a cycle until a hit or
//   a miss, then the multiply, then the divide (one quotient bit a cycle for
//   DIV_STEPS bits), then the add; the result then goes to the output register.
// A stalled receiver holds the result in the output register; the next item
//   is taken meanwhile and its result waits until the register frees.
// Reset (arst_n low) empties the table and drops any result in flight;
//   breakpoint memory contents are not cleared.
`timescale 1ns / 1ps
`include "piecewise_linear_table_interpolator_assert.svh"

module piecewise_linear_table_interpolator
	import plti_pkg::*;
#(
	parameter int MAX_POINTS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               action,
	input  logic signed [DATA_W-1:0] key_x,
	input  logic signed [DATA_W-1:0] point_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] result_value,
	output logic [1:0]               status
);

	cmd_t   cmd;
	sts_t   sts;
	state_t state;

	plti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd),
		.state    (state)
	);

	plti_dpath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.action       (action),
		.key_x        (key_x),
		.point_value  (point_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.status       (status)
	);

	`PLTI_ASSERT_SAME(a_emit_free, cmd.emit, sts.out_free, "result loaded over a pending one")
	`PLTI_ASSERT_SAME(a_walk_excl, state == PLTI_WALK, !(sts.hit && sts.miss), "hit and miss together")
	`PLTI_ASSERT_NEXT(a_div_done, state == PLTI_DIV && sts.div_last, state == PLTI_FIN, "divide overran")
	`PLTI_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid, "emitted result not presented")

endmodule

// File: verif/tb_piecewise_linear_table_interpolator.sv
// Self-checking testbench for piecewise_linear_table_interpolator.
// Needs plti_pkg and the top level; predicts each transfer from its own copy of the
// breakpoint table and checks results in order under varying back-pressure.
`timescale 1ns / 1ps

module tb_piecewise_linear_table_interpolator;
	import plti_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         status;
	} answer_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               action;
	logic signed [DATA_W-1:0] key_x;
	logic signed [DATA_W-1:0] point_value;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [DATA_W-1:0] result_value;
	logic [1:0]               status;

	// own copy of the breakpoint table
	logic signed [31:0] bp_x [TABLE_DEPTH];
	logic signed [31:0] bp_y [TABLE_DEPTH];
	int                 bp_count;

	answer_t pending_answers[$];
	int      mismatch_count;
	int      send_idle_pct;
	int      recv_stall_pct;
	int      hold_requests;
	int      hold_len;

	piecewise_linear_table_interpolator #(
		.MAX_POINTS(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.key_x(key_x),
		.point_value(point_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_value(result_value),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#6ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Interpolate inside one segment; caller guarantees x0 <= key <= x1.
	function automatic logic signed [31:0] segment_value(input logic signed [31:0] x0,
			input logic signed [31:0] y0, input logic signed [31:0] x1,
			input logic signed [31:0] y1, input logic signed [31:0] key);
		longint    dy;
		bit [63:0] dx, t, mag, quo;
		longint    r;
		dx = 64'(longint'(x1) - longint'(x0));
		t = 64'(longint'(key) - longint'(x0));
		dy = longint'(y1) - longint'(y0);
		mag = (dy < 0) ? 64'(-dy) : 64'(dy);
		if (dx == 0)
			return y0;
		quo = (mag * t) / dx;
		r = (dy < 0) ? longint'(y0) - longint'(quo) : longint'(y0) + longint'(quo);
		return r[31:0];
	endfunction

	// Applies one item to the table copy and returns the answer it should give.
	function automatic answer_t table_response(input logic [1:0] act,
			input logic signed [31:0] x, input logic signed [31:0] y);
		answer_t a;
		a.value = '0;
		a.status = ST_OK;
		case (act)
			ACT_CLEAR: bp_count = 0;
			ACT_APPEND: begin
				if (bp_count >= TABLE_DEPTH) begin
					a.status = ST_FULL;
				end else begin
					bp_x[bp_count] = x;
					bp_y[bp_count] = y;
					bp_count++;
				end
			end
			ACT_QUERY: begin
				a.status = ST_NOT_FOUND;
				for (int i = 0; i + 1 < bp_count; i++) begin
					if (bp_x[i] <= x && x <= bp_x[i + 1]) begin
						a.value = segment_value(bp_x[i], bp_y[i], bp_x[i + 1],
							bp_y[i + 1], x);
						a.status = ST_OK;
						break;
					end
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 15))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic flag_error(input string what, input answer_t want, input answer_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected value %h status %0d, got value %h status %0d",
				$realtime, what, want.value, want.status, got.value, got.status);
	endtask

	// Offers one item, holds it until the transfer, then records the answer.
	task automatic send_item(input logic [1:0] act, input logic signed [31:0] x,
			input logic signed [31:0] y);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		key_x <= x;
		point_value <= y;
		do @(posedge clk); while (!in_ready);
		pending_answers.insert(pending_answers.size(), table_response(act, x, y));
	endtask

	// Receiver: random stalls, plus long hold-offs on request.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		answer_t got;
		answer_t want;
		if (arst_n && out_valid && out_ready) begin
			got.value = result_value;
			got.status = status;
			if (pending_answers.size() == 0) begin
				want = '0;
				flag_error("result with nothing outstanding", want, got);
			end else begin
				want = pending_answers.pop_front();
				if (got.value !== want.value)
					flag_error("result_value mismatch", want, got);
				if (got.status !== want.status)
					flag_error("status mismatch", want, got);
			end
		end
	end

	task automatic set_traffic(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic test_empty_table();
		send_item(ACT_QUERY, Q_MAX, '0);
		send_item(ACT_UNUSED, -32'sd1, -32'sd1);
	endtask

	// One segment across the whole number range, falling from MAX to MIN.
	task automatic test_extreme_segment();
		send_item(ACT_APPEND, Q_MIN, Q_MAX);
		send_item(ACT_QUERY, Q_MIN, '0);
		send_item(ACT_APPEND, Q_MAX, Q_MIN);
		send_item(ACT_QUERY, Q_MIN, Q_MAX);
		send_item(ACT_QUERY, Q_MAX, Q_MIN);
		send_item(ACT_QUERY, '0, '0);
	endtask

	task automatic test_zero_width();
		send_item(ACT_CLEAR, Q_MAX, Q_MAX);
		send_item(ACT_APPEND, Q_ONE, 32'sh0003_4000);
		send_item(ACT_APPEND, Q_ONE, -32'sh0002_0000);
		send_item(ACT_QUERY, Q_ONE, '0);
		send_item(ACT_QUERY, Q_ONE - 1, '0);
	endtask

	// Tops up the two-point table to full, then one append too many.
	task automatic test_full_table();
		for (int i = 2; i < TABLE_DEPTH; i++)
			send_item(ACT_APPEND, Q_ONE * i, 32'sh0000_7000 * i - 32'sh0004_0000);
		send_item(ACT_APPEND, Q_MAX, Q_MAX);
		send_item(ACT_QUERY, Q_ONE * (TABLE_DEPTH - 1) - 32'sh8000, '0);
	endtask

	// Receiver holds off while the sender keeps offering, so the block backs up.
	task automatic test_back_pressure();
		hold_len = 300;
		hold_requests++;
		for (int i = 0; i < 20; i++)
			send_item(($urandom_range(0, 2) == 0) ? ACT_APPEND : ACT_QUERY,
				pick_word(), pick_word());
	endtask

	// Mostly whole tables (clear, appends, queries) with random content; some noise.
	task automatic test_random_tables(input int item_goal);
		int                 sent, n_pts, n_q, stored, mode;
		logic signed [31:0] px [TABLE_DEPTH + 3];
		logic signed [31:0] tmp, base, ybase, k;
		logic [1:0]         act;
		longint             lo, hi;
		bit [63:0]          r;
		sent = 0;
		while (sent < item_goal) begin
			if ($urandom_range(0, 99) < 12) begin
				act = 2'($urandom_range(0, 3));
				send_item(act, pick_word(), pick_word());
				if (act != ACT_UNUSED)
					sent++;
			end else begin
				n_pts = ($urandom_range(0, 9) == 0) ?
					$urandom_range(TABLE_DEPTH, TABLE_DEPTH + 3) :
					$urandom_range(0, TABLE_DEPTH);
				mode = $urandom_range(0, 4);
				base = pick_word();
				ybase = pick_word();
				for (int i = 0; i < n_pts; i++) begin
					case (mode)
						0, 4: px[i] = pick_word();
						1: px[i] = base + ($urandom_range(0, 255) << 10);
						2: px[i] = base + ($urandom_range(0, 3) << 16);
						default: px[i] = $urandom;
					endcase
				end
				// ascending order except in the last mode
				if (mode != 4) begin
					for (int i = 1; i < n_pts; i++) begin
						tmp = px[i];
						for (int j = i; j > 0; j--) begin
							if (px[j - 1] <= tmp)
								break;
							px[j] = px[j - 1];
							px[j - 1] = tmp;
						end
					end
				end
				if ($urandom_range(0, 9) != 0) begin
					send_item(ACT_CLEAR, pick_word(), pick_word());
					sent++;
				end
				for (int i = 0; i < n_pts; i++)
					send_item(ACT_APPEND, px[i], $urandom_range(0, 1) ?
						pick_word() : ybase + $urandom_range(0, 32'h3FFFF));
				sent += n_pts;
				stored = (n_pts < TABLE_DEPTH) ? n_pts : TABLE_DEPTH;
				lo = (stored > 0) ? longint'(px[0]) : 0;
				hi = lo;
				for (int i = 1; i < stored; i++) begin
					if (longint'(px[i]) < lo)
						lo = longint'(px[i]);
					if (longint'(px[i]) > hi)
						hi = longint'(px[i]);
				end
				n_q = $urandom_range(1, 10);
				for (int q = 0; q < n_q; q++) begin
					r = {$urandom, $urandom};
					case ($urandom_range(0, 9))
						0: k = pick_word();
						1: k = (stored > 0) ? px[$urandom_range(0, stored - 1)] : '0;
						2: k = 32'((lo > longint'(Q_MIN)) ? lo - 1 : lo);
						3: k = 32'((hi < longint'(Q_MAX)) ? hi + 1 : hi);
						default: k = 32'(lo + longint'(r % 64'(hi - lo + 1)));
					endcase
					send_item(ACT_QUERY, k, pick_word());
				end
				sent += n_q;
			end
		end
	endtask

	initial begin
		int guard;
		answer_t none;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_CLEAR;
		key_x = '0;
		point_value = '0;
		bp_count = 0;
		mismatch_count = 0;
		hold_requests = 0;
		hold_len = 0;
		set_traffic(0, 0);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_extreme_segment();
		test_zero_width();
		test_full_table();
		test_back_pressure();
		test_random_tables(480);
		set_traffic(78, 0);
		test_random_tables(330);
		set_traffic(0, 78);
		test_random_tables(330);
		set_traffic(10, 10);
		test_random_tables(330);

		@(negedge clk);
		in_valid <= 1'b0;
		guard = 0;
		while (pending_answers.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (64) @(posedge clk);
		none = '0;
		while (pending_answers.size() != 0)
			flag_error("result never arrived", pending_answers.pop_front(), none);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/plti_pkg.sv
rtl/core/plti_ctrl.sv
rtl/core/plti_dpath.sv
rtl/core/piecewise_linear_table_interpolator.sv
verif/tb_piecewise_linear_table_interpolator.sv
